// ===== hw/rtl/chm_pkg.sv =====
// Package for the compass heading block: widths, fixed-point constants and
// the arctangent table of the angle pipeline. No dependencies.
package chm_pkg;

   // Number of rotation steps, capped at the length of the arctangent table.
   localparam int ANGLE_STEPS = 16;
   localparam int AtanLen     = 24;
   localparam int NumSteps    = (ANGLE_STEPS > AtanLen) ? AtanLen : ANGLE_STEPS;

   // Field and datapath widths.
   localparam int MagW     = 16;
   localparam int DiffW    = 17;
   localparam int PosW     = 28;
   localparam int AngW     = 27;
   localparam int WrapW    = 25;
   localparam int HeadW    = 15;
   localparam int RoundW   = 16;
   localparam int PreShift = 8;
   localparam int OutShift = 10;

   // Register indexes of the configuration port.
   localparam logic CsrOffsetX = 1'b0;
   localparam logic CsrOffsetY = 1'b1;

   typedef logic signed [DiffW-1:0] diff_type;
   typedef logic signed [PosW-1:0]  pos_type;
   typedef logic signed [AngW-1:0]  ang_type;

   // Angles are degrees with 16 fraction bits.
   localparam ang_type HalfTurn = ang_type'(180 * 65536);
   localparam ang_type FullTurn = ang_type'(360 * 65536);
   localparam logic [WrapW-1:0]  RoundHalf   = WrapW'(512);
   localparam logic [RoundW-1:0] FullTurnOut = RoundW'(23040);

   // Arctangent of 2^-i in degrees, rounded at 16 fraction bits.
   function automatic ang_type atan_deg(input logic [4:0] idx);
      ang_type val;
      case (idx)
         5'd0:    val = ang_type'(2949120);
         5'd1:    val = ang_type'(1740967);
         5'd2:    val = ang_type'(919879);
         5'd3:    val = ang_type'(466945);
         5'd4:    val = ang_type'(234379);
         5'd5:    val = ang_type'(117304);
         5'd6:    val = ang_type'(58666);
         5'd7:    val = ang_type'(29335);
         5'd8:    val = ang_type'(14668);
         5'd9:    val = ang_type'(7334);
         5'd10:   val = ang_type'(3667);
         5'd11:   val = ang_type'(1833);
         5'd12:   val = ang_type'(917);
         5'd13:   val = ang_type'(458);
         5'd14:   val = ang_type'(229);
         5'd15:   val = ang_type'(115);
         5'd16:   val = ang_type'(57);
         5'd17:   val = ang_type'(29);
         5'd18:   val = ang_type'(14);
         5'd19:   val = ang_type'(7);
         5'd20:   val = ang_type'(4);
         5'd21:   val = ang_type'(2);
         5'd22:   val = ang_type'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== hw/rtl/compass_heading_from_magnetometer.sv =====
// Compass heading pipeline: offset removal, unrolled vectoring rotations and
// heading rounding. Depends on chm_pkg.
//
// The block takes one magnetometer beat (x, y) per cycle, removes the
// hard-iron offsets, finds atan2(y, x) with one register stage per rotation
// step and returns the heading in 1/64 degree units, from 0 to just under
// 360 degrees; a zero vector reads as heading 0. A new sample is accepted in
// every cycle in which the result side is not stalled. Each sample passes
// through one stage for the offset subtract, one for the start vector, one
// per rotation step, then the wrap into the full circle and the output
// register. A stall on the result side while a heading waits there freezes
// the whole pipeline and is passed back to the request side in the same
// cycle. Offsets should be written only while no sample is in flight.
module compass_heading_from_magnetometer
   import chm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [MagW-1:0]  req_mag_x,
   input  logic signed [MagW-1:0]  req_mag_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [HeadW-1:0]        rsp_heading,
   input  logic                    csr_write,
   input  logic                    csr_index,
   input  logic [MagW-1:0]         csr_wdata
);

   logic signed [MagW-1:0] offset_x_ff;
   logic signed [MagW-1:0] offset_y_ff;

   logic     advance;
   logic     a_valid_ff;
   diff_type a_dx_ff;
   diff_type a_dy_ff;

   logic    v_ff    [0:NumSteps];
   logic    zero_ff [0:NumSteps];
   pos_type x_ff    [0:NumSteps];
   pos_type y_ff    [0:NumSteps];
   ang_type z_ff    [0:NumSteps];

   pos_type x_in    [1:NumSteps];
   pos_type y_in    [1:NumSteps];
   ang_type z_in    [1:NumSteps];

   pos_type x_start_in;
   pos_type y_start_in;
   ang_type z_start_in;

   logic             c_valid_ff;
   logic             c_zero_ff;
   logic [WrapW-1:0] c_z_ff;
   ang_type          c_z_in;

   logic [RoundW-1:0] round_sum;
   logic [RoundW-1:0] round_wrap;
   logic              rsp_valid_ff;
   logic [HeadW-1:0]  rsp_heading_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= '0;
         offset_y_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CsrOffsetX: offset_x_ff <= csr_wdata;
            CsrOffsetY: offset_y_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   // The whole pipeline moves unless a finished beat waits at the output.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Stage A: subtract the offsets at 17 bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_dx_ff <= diff_type'(req_mag_x) - diff_type'(offset_x_ff);
         a_dy_ff <= diff_type'(req_mag_y) - diff_type'(offset_y_ff);
      end
   end

   // Start vector: prescale, and fold the left half plane over by 180 degrees.
   always_comb begin
      x_start_in = pos_type'(a_dx_ff) <<< PreShift;
      y_start_in = pos_type'(a_dy_ff) <<< PreShift;
      z_start_in = '0;
      if (a_dx_ff[DiffW-1]) begin
         x_start_in = -x_start_in;
         y_start_in = -y_start_in;
         z_start_in = HalfTurn;
      end
   end

   // One rotation step per stage, driving y toward zero.
   always_comb begin
      for (int i = 0; i < NumSteps; i++) begin
         if (!y_ff[i][PosW-1]) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + atan_deg(5'(i));
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - atan_deg(5'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NumSteps; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         v_ff[0] <= a_valid_ff;
         for (int i = 1; i <= NumSteps; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= x_start_in;
         y_ff[0]    <= y_start_in;
         z_ff[0]    <= z_start_in;
         zero_ff[0] <= (a_dx_ff == '0) && (a_dy_ff == '0);
         for (int i = 1; i <= NumSteps; i++) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            zero_ff[i] <= zero_ff[i-1];
         end
      end
   end

   // Stage C: wrap negative angles into the full circle.
   assign c_z_in = z_ff[NumSteps][AngW-1] ? (z_ff[NumSteps] + FullTurn) : z_ff[NumSteps];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= v_ff[NumSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_z_ff    <= c_z_in[WrapW-1:0];
         c_zero_ff <= zero_ff[NumSteps];
      end
   end

   // Output stage: round to 1/64 degree, half up, and fold a full turn to 0.
   always_comb begin
      round_sum  = RoundW'((c_z_ff + RoundHalf) >> OutShift);
      round_wrap = (round_sum >= FullTurnOut) ? (round_sum - FullTurnOut) : round_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_heading_ff <= c_zero_ff ? '0 : round_wrap[HeadW-1:0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_heading = rsp_heading_ff;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for compass_heading_from_magnetometer: a fixed table
// of samples, then randomized samples under several hard-iron offset settings.
// Depends on chm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
   import chm_pkg::*;

   localparam int  ClockHalf    = 2;
   localparam int  PipeDepth    = NumSteps + 3;
   localparam int  CycleLimit   = 300000;
   localparam int  RandomPhases = 7;
   localparam int  PerPhase     = 219;
   localparam int  DirRows      = 24;

   // Fixed-point constants of the heading computation.
   localparam longint Prescale    = 256;
   localparam longint HalfTurnQ16 = 180 * 65536;
   localparam longint FullTurnQ16 = 360 * 65536;
   localparam longint RoundBias   = 512;
   localparam longint FullCircle  = 23040;

   // atan(2^-i) in degrees with 16 fraction bits.
   localparam int AtanQ16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct {
      int mx;
      int my;
      bit known;
      int heading;
   } sample_row_type;

   typedef struct {
      logic signed [MagW-1:0] mx;
      logic signed [MagW-1:0] my;
      logic [HeadW-1:0]       heading;
   } heading_due_type;

   // Fixed samples, taken with the offsets at their reset value of zero.
   // Headings are typed in only for the axes, the diagonals at 20000 and the zero vector.
   sample_row_type sample_table [DirRows] = '{
      '{0, 0, 1, 0},
      '{32767, 0, 1, 0},
      '{0, 32767, 1, 5760},
      '{-32768, 0, 1, 11520},
      '{0, -32768, 1, 17280},
      '{20000, 20000, 1, 2880},
      '{-20000, 20000, 1, 8640},
      '{-20000, -20000, 1, 14400},
      '{20000, -20000, 1, 20160},
      '{32767, 32767, 0, 0},
      '{-32768, -32768, 0, 0},
      '{-32768, 32767, 0, 0},
      '{32767, -32768, 0, 0},
      '{1, 0, 0, 0},
      '{0, 1, 0, 0},
      '{-1, 0, 0, 0},
      '{0, -1, 0, 0},
      '{1, 1, 0, 0},
      '{-1, -1, 0, 0},
      '{-1, 1, 0, 0},
      '{1, -1, 0, 0},
      '{32767, -1, 0, 0},
      '{-32768, 1, 0, 0},
      '{-32768, -1, 0, 0}
   };

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic signed [MagW-1:0] req_mag_x   = '0;
   logic signed [MagW-1:0] req_mag_y   = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   logic [HeadW-1:0]       rsp_heading;
   logic                   csr_write   = 1'b0;
   logic                   csr_index   = CsrOffsetX;
   logic [MagW-1:0]        csr_wdata   = '0;

   // Offsets as the block should hold them.
   logic signed [MagW-1:0] offset_x = '0;
   logic signed [MagW-1:0] offset_y = '0;

   heading_due_type headings_due [$];
   int samples_sent   = 0;
   int headings_seen  = 0;
   int offset_setups  = 1;
   int failures       = 0;
   int cycle_count    = 0;
   int tx_idle_pct    = 0;
   int rx_idle_pct    = 0;

   compass_heading_from_magnetometer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mag_x   (req_mag_x),
      .req_mag_y   (req_mag_y),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_heading (rsp_heading),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #(ClockHalf) clock = ~clock;

   // Heading of one sample: offset removal, vectoring rotations, wrap and round.
   function automatic logic [HeadW-1:0] heading_of_sample(
      input logic signed [MagW-1:0] mx,
      input logic signed [MagW-1:0] my
   );
      diff_type dx;
      diff_type dy;
      longint   x;
      longint   y;
      longint   z;
      longint   nx;
      longint   ny;
      longint   h;
      dx = diff_type'(mx) - diff_type'(offset_x);
      dy = diff_type'(my) - diff_type'(offset_y);
      if (dx == 0 && dy == 0) begin
         return '0;
      end
      x = longint'(dx) * Prescale;
      y = longint'(dy) * Prescale;
      z = 0;
      // Fold the left half plane onto the right one.
      if (x < 0) begin
         x = -x;
         y = -y;
         z = HalfTurnQ16;
      end
      for (int i = 0; i < NumSteps; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z  = z + AtanQ16[i];
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z  = z - AtanQ16[i];
         end
         x = nx;
         y = ny;
      end
      if (z < 0) begin
         z = z + FullTurnQ16;
      end
      if (z < 0) begin
         z = 0;
      end
      // Round to 1/64 degree; a full circle reads as zero.
      h = (z + RoundBias) >>> 10;
      if (h >= FullCircle) begin
         h = h - FullCircle;
      end
      return h[HeadW-1:0];
   endfunction

   // Field values weighted toward extremes, zero differences and small vectors.
   function automatic logic signed [MagW-1:0] pick_field(input logic signed [MagW-1:0] offset);
      logic signed [MagW-1:0] val;
      case ($urandom_range(0, 7))
         0, 1, 2, 3: val = MagW'($urandom);
         4: begin
            case ($urandom_range(0, 4))
               0:       val = 16'sh8000;
               1:       val = 16'sh7FFF;
               2:       val = 16'sh0000;
               3:       val = 16'shFFFF;
               default: val = 16'sh0001;
            endcase
         end
         5:       val = offset;
         6:       val = offset + MagW'($urandom_range(0, 16)) - 16'sd8;
         default: val = MagW'($urandom_range(0, 127)) - 16'sd64;
      endcase
      return val;
   endfunction

   // Send one sample beat and record the heading it should produce.
   task automatic send_sample(
      input logic signed [MagW-1:0] mx,
      input logic signed [MagW-1:0] my,
      input bit                     known,
      input logic [HeadW-1:0]       fixed_heading
   );
      heading_due_type due;
      if (samples_sent < 510) begin
         tx_idle_pct = 34;
         rx_idle_pct = 64;
      end else if (samples_sent < 1020) begin
         tx_idle_pct = 64;
         rx_idle_pct = 34;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mag_x <= mx;
      req_mag_y <= my;
      do @(posedge clock); while (req_stall);
      due.mx      = mx;
      due.my      = my;
      due.heading = known ? fixed_heading : heading_of_sample(mx, my);
      headings_due.push_back(due);
      samples_sent++;
   endtask

   // Hold off until every heading has come and the pipeline has emptied.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (headings_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (PipeDepth + 2) @(posedge clock);
   endtask

   // Write the X offset and then the Y offset, the block being idle.
   task automatic load_offsets(input logic signed [MagW-1:0] ox, input logic signed [MagW-1:0] oy);
      csr_write <= 1'b1;
      csr_index <= CsrOffsetX;
      csr_wdata <= ox;
      @(posedge clock);
      csr_index <= CsrOffsetY;
      csr_wdata <= oy;
      @(posedge clock);
      csr_write <= 1'b0;
      offset_x = ox;
      offset_y = oy;
      offset_setups++;
   endtask

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
   end

   // Compare each heading beat with the oldest one due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         headings_seen++;
         if (headings_due.size() == 0) begin
            failures++;
            $display("%0t: heading %0d arrived with none due", $time, rsp_heading);
         end else begin
            if (rsp_heading !== headings_due[0].heading) begin
               failures++;
               $display("%0t: heading for x=%0d y=%0d: expected %0d, actual %0d",
                        $time, headings_due[0].mx, headings_due[0].my,
                        headings_due[0].heading, rsp_heading);
            end
            void'(headings_due.pop_front());
         end
      end
   end

   // Run guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      logic signed [MagW-1:0] ox;
      logic signed [MagW-1:0] oy;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fixed table with the offsets still at reset.
      for (int r = 0; r < DirRows; r++) begin
         send_sample(MagW'(sample_table[r].mx), MagW'(sample_table[r].my),
                     sample_table[r].known, HeadW'(sample_table[r].heading));
      end

      // Random samples, one offset setting per phase.
      for (int p = 0; p < RandomPhases; p++) begin
         wait_for_drain();
         case (p)
            0: begin ox = 16'sh0000; oy = 16'sh0000; end
            1: begin ox = 16'sh7FFF; oy = 16'sh8000; end
            2: begin ox = 16'sh8000; oy = 16'sh7FFF; end
            3: begin ox = 16'sh8000; oy = 16'sh8000; end
            4: begin ox = 16'sh7FFF; oy = 16'sh7FFF; end
            default: begin ox = MagW'($urandom); oy = MagW'($urandom); end
         endcase
         load_offsets(ox, oy);
         for (int k = 0; k < PerPhase; k++) begin
            send_sample(pick_field(offset_x), pick_field(offset_y), 1'b0, '0);
         end
      end

      wait_for_drain();
      $display("Sent %0d samples across %0d offset settings; %0d headings compared.",
               samples_sent, offset_setups, headings_seen);
      $display("Sender and receiver idled in turn, then ran back to back; %0d mismatches.",
               failures);
      if (failures == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/chm_pkg.sv
hw/rtl/compass_heading_from_magnetometer.sv
tb/testbench.sv
